/* src/plt_pkg.sv */
`timescale 1ns / 1ps

package plt_pkg;

  // slot and compare widths cover the largest supported capacity
  localparam int SLOT_W = 8;
  localparam int CMP_W  = 9;

  typedef enum logic [2:0] {
    REQ_INS_POS  = 3'd0,
    REQ_INS_HEAD = 3'd1,
    REQ_INS_TAIL = 3'd2,
    REQ_DEL_POS  = 3'd3,
    REQ_DEL_HEAD = 3'd4,
    REQ_DEL_TAIL = 3'd5,
    REQ_READ     = 3'd6,
    REQ_NONE     = 3'd7
  } req_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_BADPOS = 2'd3
  } status_t;

  typedef struct packed {
    req_t        req_type;
    logic [4:0]  position;
    logic [31:0] entry_value;
  } in_item_t;

  typedef struct packed {
    status_t     status;
    logic [31:0] read_value;
    logic [4:0]  entry_count;
  } out_item_t;

  // command broadcast to every cell in the row
  typedef struct packed {
    logic              ins;
    logic              del;
    logic [SLOT_W-1:0] slot;
  } cell_cmd_t;

endpackage

/* src/plt_cell.sv */
`timescale 1ns / 1ps

module plt_cell #(
  parameter int IDX         = 0,
  parameter int ENTRY_WIDTH = 32
) (
  input  logic                   clk,
  input  plt_pkg::cell_cmd_t     cmd,
  input  logic [ENTRY_WIDTH-1:0] new_val,
  input  logic [ENTRY_WIDTH-1:0] left_val,
  input  logic [ENTRY_WIDTH-1:0] right_val,
  output logic [ENTRY_WIDTH-1:0] val_q
);

  localparam logic [plt_pkg::SLOT_W-1:0] MY_IDX = plt_pkg::SLOT_W'(IDX);

  logic [ENTRY_WIDTH-1:0] val_r;
  logic [ENTRY_WIDTH-1:0] val_nxt;

  always_comb begin
    val_nxt = val_r;
    if (cmd.ins) begin
      if (cmd.slot == MY_IDX) begin
        val_nxt = new_val;
      end else if (cmd.slot < MY_IDX) begin
        val_nxt = left_val;
      end
    end else if (cmd.del && (cmd.slot <= MY_IDX)) begin
      val_nxt = right_val;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign val_q = val_r;

endmodule

/* src/positional_list_table.sv */
`timescale 1ns / 1ps

// channel  direction  handshake            payload
// in_      input      in_valid / in_ready    plt_pkg::in_item_t  (req_type, position, entry_value)
// out_     output     out_valid / out_ready  plt_pkg::out_item_t (status, read_value, entry_count)
//
// one request per cycle while the output is taken: every cell picks its left neighbor, its right
// neighbor, itself or the new value in the cycle of the transfer
// the result is registered and appears the cycle after the transfer
// in_ready is high while the result register is empty or being taken
// reset (rst_n low, synchronous) empties the list; entry cells are not cleared
// a stalled output holds its result and blocks new requests

module positional_list_table #(
  parameter int CAPACITY    = 16,
  parameter int ENTRY_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  plt_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output plt_pkg::out_item_t out_data
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CW    = plt_pkg::CMP_W;

  // entry count and result register
  logic [CNT_W-1:0]   cnt_r;
  logic [CNT_W-1:0]   cnt_nxt;
  logic               out_valid_r;
  plt_pkg::out_item_t out_r;
  plt_pkg::out_item_t out_nxt;

  logic               in_fire;
  plt_pkg::cell_cmd_t cmd;

  // comparisons run in one common width
  logic [CW-1:0] cnt_w;
  logic [CW-1:0] pos_w;
  logic [CW-1:0] slot_w;
  logic [CW-1:0] cnt_after;
  logic          is_full;
  logic          is_empty;
  plt_pkg::status_t status_nxt;

  logic [63:0]            ins_ext;
  logic [ENTRY_WIDTH-1:0] ins_val;
  logic [ENTRY_WIDTH-1:0] rd_sel;
  logic [63:0]            rd_ext;
  logic                   rd_ok;

  logic [ENTRY_WIDTH-1:0] cell_q [CAPACITY];

  assign in_fire  = in_valid && in_ready;
  assign in_ready = !out_valid_r || out_ready;

  assign cnt_w    = CW'(cnt_r);
  assign pos_w    = CW'(in_data.position);
  assign is_full  = (cnt_w == CW'(CAPACITY));
  assign is_empty = (cnt_w == '0);

  // insert value kept to entry width
  assign ins_ext = 64'(in_data.entry_value);
  assign ins_val = ins_ext[ENTRY_WIDTH-1:0];

  // request decode: status, target slot, and the command for the row
  always_comb begin
    status_nxt = plt_pkg::ST_OK;
    slot_w     = '0;
    cmd.ins    = 1'b0;
    cmd.del    = 1'b0;
    rd_ok      = 1'b0;
    case (in_data.req_type)
      plt_pkg::REQ_INS_POS, plt_pkg::REQ_INS_HEAD, plt_pkg::REQ_INS_TAIL: begin
        if (in_data.req_type == plt_pkg::REQ_INS_POS) begin
          slot_w = pos_w;
        end else if (in_data.req_type == plt_pkg::REQ_INS_TAIL) begin
          slot_w = cnt_w;
        end
        if (is_full) begin
          status_nxt = plt_pkg::ST_FULL;
        end else if (slot_w > cnt_w) begin
          status_nxt = plt_pkg::ST_BADPOS;
        end else begin
          cmd.ins = 1'b1;
        end
      end
      plt_pkg::REQ_DEL_POS, plt_pkg::REQ_DEL_HEAD, plt_pkg::REQ_DEL_TAIL: begin
        if (in_data.req_type == plt_pkg::REQ_DEL_POS) begin
          slot_w = pos_w;
        end else if (in_data.req_type == plt_pkg::REQ_DEL_TAIL) begin
          slot_w = cnt_w - CW'(1);
        end
        if (is_empty) begin
          status_nxt = plt_pkg::ST_EMPTY;
        end else if (slot_w >= cnt_w) begin
          status_nxt = plt_pkg::ST_BADPOS;
        end else begin
          cmd.del = 1'b1;
        end
      end
      plt_pkg::REQ_READ: begin
        slot_w = pos_w;
        if (is_empty) begin
          status_nxt = plt_pkg::ST_EMPTY;
        end else if (pos_w >= cnt_w) begin
          status_nxt = plt_pkg::ST_BADPOS;
        end else begin
          rd_ok = 1'b1;
        end
      end
      default: begin
        status_nxt = plt_pkg::ST_OK;
      end
    endcase
    // the row only moves on a transfer
    cmd.ins  = cmd.ins && in_fire;
    cmd.del  = cmd.del && in_fire;
    cmd.slot = slot_w[plt_pkg::SLOT_W-1:0];
  end

  // read port: one-hot select over the row
  always_comb begin
    rd_sel = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (pos_w == CW'(i)) begin
        rd_sel = cell_q[i];
      end
    end
  end

  assign rd_ext = 64'(rd_sel);

  always_comb begin
    cnt_after = cnt_w;
    if (cmd.ins) begin
      cnt_after = cnt_w + CW'(1);
    end else if (cmd.del) begin
      cnt_after = cnt_w - CW'(1);
    end
    cnt_nxt              = cnt_after[CNT_W-1:0];
    out_nxt.status       = status_nxt;
    out_nxt.read_value   = rd_ok ? rd_ext[31:0] : 32'd0;
    out_nxt.entry_count  = cnt_after[4:0];
  end

  // row of cells, each seeing its two neighbors; the ends see themselves
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [ENTRY_WIDTH-1:0] left_v;
    logic [ENTRY_WIDTH-1:0] right_v;
    if (g == 0) begin : g_first
      assign left_v = cell_q[g];
    end else begin : g_mid_l
      assign left_v = cell_q[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign right_v = cell_q[g];
    end else begin : g_mid_r
      assign right_v = cell_q[g+1];
    end
    plt_cell #(
      .IDX         (g),
      .ENTRY_WIDTH (ENTRY_WIDTH)
    ) u_cell (
      .clk       (clk),
      .cmd       (cmd),
      .new_val   (ins_val),
      .left_val  (left_v),
      .right_val (right_v),
      .val_q     (cell_q[g])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        cnt_r       <= cnt_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // list never holds more than its capacity
  assert property (@(posedge clk) disable iff (!rst_n)
    cnt_w <= CW'(CAPACITY))
    else $error("entry count above capacity");

  // a waiting result reports the count now held
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_r.entry_count == cnt_w[4:0]))
    else $error("reported count differs from held count");

  // a refused request leaves the list size alone
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && (status_nxt != plt_pkg::ST_OK)) |=> $stable(cnt_r))
    else $error("count moved on a refused request");

  // a successful insert grows the list by one
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.ins |=> (CW'(cnt_r) == $past(cnt_w) + CW'(1)))
    else $error("insert did not grow the list");

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
  import plt_pkg::*;

  localparam int          CAP         = 16;
  localparam int          RAND_ITEMS  = 400;
  localparam int unsigned CYCLE_LIMIT = 200000;
  // the result is registered after the transfer, and this settle margin covers it
  localparam int          SETTLE      = 10;

  // list predictor plus the queue of results still owed by the block
  class table_checker;
    logic [31:0] slots [CAP];
    int unsigned held;
    int unsigned errors;
    out_item_t   awaited_results [$];

    function new();
      held   = 0;
      errors = 0;
    endfunction

    // shift slots up from the insert point, full check before position check
    function status_t insert_at(int unsigned slot, logic [31:0] value);
      if (held >= CAP) return ST_FULL;
      if (slot > held) return ST_BADPOS;
      for (int unsigned i = held; i > slot; i--) slots[i] = slots[i - 1];
      slots[slot] = value;
      held++;
      return ST_OK;
    endfunction

    // close the gap by shifting later slots down, empty check first
    function status_t remove_at(int unsigned slot);
      if (held == 0) return ST_EMPTY;
      if (slot >= held) return ST_BADPOS;
      for (int unsigned i = slot; i + 1 < held; i++) slots[i] = slots[i + 1];
      held--;
      return ST_OK;
    endfunction

    function void note_request(in_item_t req);
      out_item_t res;
      res.status     = ST_OK;
      res.read_value = '0;
      case (req.req_type)
        REQ_INS_POS:  res.status = insert_at(req.position, req.entry_value);
        REQ_INS_HEAD: res.status = insert_at(0, req.entry_value);
        REQ_INS_TAIL: res.status = insert_at(held, req.entry_value);
        REQ_DEL_POS:  res.status = remove_at(req.position);
        REQ_DEL_HEAD: res.status = remove_at(0);
        REQ_DEL_TAIL: res.status = (held == 0) ? ST_EMPTY : remove_at(held - 1);
        REQ_READ: begin
          if (held == 0)
            res.status = ST_EMPTY;
          else if (req.position >= held)
            res.status = ST_BADPOS;
          else
            res.read_value = slots[req.position];
        end
        default: ;
      endcase
      res.entry_count = 5'(held);
      awaited_results.push_back(res);
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (awaited_results.size() == 0) begin
        $error("result with nothing awaited: status %0d read_value %h entry_count %0d",
               got.status, got.read_value, got.entry_count);
        errors++;
        return;
      end
      want = awaited_results.pop_front();
      if (got.status !== want.status) begin
        $error("status: expected %0d, actual %0d", want.status, got.status);
        errors++;
      end
      if (got.read_value !== want.read_value) begin
        $error("read_value: expected %h, actual %h", want.read_value, got.read_value);
        errors++;
      end
      if (got.entry_count !== want.entry_count) begin
        $error("entry_count: expected %0d, actual %0d", want.entry_count, got.entry_count);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return awaited_results.size();
    endfunction
  endclass

  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  table_checker chk = new();

  int unsigned cycle_count = 0;
  // receiver stall pattern: a mode held for a random stretch of cycles
  int unsigned ready_left  = 0;
  int unsigned ready_mode  = 0;
  // steers random traffic toward a full or an empty list
  bit          grow_phase  = 1'b1;

  positional_list_table i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #1 clk = ~clk;

  // hard stop in case the block hangs
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  // receiver: always ready, coin-flip, or mostly stalled, in random stretches
  always @(posedge clk) begin
    if (ready_left == 0) begin
      ready_mode <= $urandom_range(0, 2);
      ready_left <= $urandom_range(4, 40);
    end else begin
      ready_left <= ready_left - 1;
    end
    case (ready_mode)
      0:       out_ready <= 1'b1;
      1:       out_ready <= 1'($urandom_range(0, 1));
      default: out_ready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  // monitor: values read here are the ones present before the edge,
  // since every driver and the block update through nonblocking assignments
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) chk.check_result(out_data);
      if (in_valid && in_ready) chk.note_request(in_data);
    end
  end

  // hold the request until its transfer; called at a rising edge
  task automatic send_request(input in_item_t req);
    in_data  <= req;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic apply(input req_t kind, input int unsigned pos, input logic [31:0] value);
    in_item_t req;
    req.req_type    = kind;
    req.position    = 5'(pos);
    req.entry_value = value;
    send_request(req);
  endtask

  task automatic idle_for(input int unsigned n);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // stop sending until every owed result has come back
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (chk.pending() != 0);
  endtask

  // mostly well-formed positions, now and then anything the field can hold
  function automatic in_item_t random_request();
    in_item_t    req;
    int unsigned pick;
    int unsigned held;
    held = chk.held;
    pick = $urandom_range(0, 99);
    case ($urandom_range(0, 9))
      0:       req.entry_value = '0;
      1:       req.entry_value = '1;
      default: req.entry_value = $urandom();
    endcase
    if (pick < 3)
      req.req_type = REQ_NONE;
    else if (pick < 15)
      req.req_type = REQ_READ;
    else if (pick < (grow_phase ? 72 : 38))
      req.req_type = req_t'($urandom_range(0, 2));
    else
      req.req_type = req_t'($urandom_range(3, 5));
    if ($urandom_range(0, 7) == 0)
      req.position = 5'($urandom_range(0, 31));
    else if (req.req_type inside {REQ_INS_POS, REQ_INS_HEAD, REQ_INS_TAIL})
      req.position = 5'($urandom_range(0, held));
    else
      req.position = 5'($urandom_range(0, (held > 0) ? held - 1 : 0));
    return req;
  endfunction

  initial begin
    int unsigned sent;
    int unsigned burst;
    int unsigned gap;

    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // empty list: deletes and reads report empty, even with a bad position
    apply(REQ_DEL_POS, 5, '0);
    apply(REQ_DEL_HEAD, 0, '0);
    apply(REQ_DEL_TAIL, 0, '0);
    apply(REQ_READ, 0, '0);
    // unused request type leaves everything alone
    apply(REQ_NONE, 31, '1);
    // positional insert past the end of an empty list
    apply(REQ_INS_POS, 1, 32'h1234_5678);
    // fill to capacity through all three insert kinds, extreme values first
    for (int unsigned i = 0; i < CAP; i++) begin
      case (i % 3)
        0: apply(REQ_INS_POS, $urandom_range(0, i),
                 (i == 0) ? 32'h0 : $urandom());
        1: apply(REQ_INS_HEAD, 0, (i == 1) ? 32'hFFFF_FFFF : $urandom());
        default: apply(REQ_INS_TAIL, 0, $urandom());
      endcase
    end
    // full list with a bad position: full wins
    apply(REQ_INS_POS, 17, $urandom());
    apply(REQ_READ, 16, '0);
    apply(REQ_READ, 15, '0);
    apply(REQ_DEL_POS, 31, '0);
    drain();

    // random traffic in bursts, swinging between full and empty
    sent = 0;
    while (sent < RAND_ITEMS) begin
      burst = $urandom_range(1, 20);
      for (int unsigned k = 0; k < burst && sent < RAND_ITEMS; k++) begin
        send_request(random_request());
        sent++;
        if (chk.held >= CAP - 1)
          grow_phase = 1'b0;
        else if (chk.held <= 1)
          grow_phase = 1'b1;
        else if ($urandom_range(0, 39) == 0)
          grow_phase = ~grow_phase;
      end
      if ($urandom_range(0, 19) == 0) begin
        drain();
      end else begin
        // a quarter of the bursts that do not drain run straight into the next one
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        if (gap > 0) idle_for(gap);
      end
    end

    drain();
    repeat (SETTLE) @(posedge clk);
    if (chk.errors == 0)
      $display("tb_top: clean");
    else
      $display("tb_top: errors");
    $finish;
  end

endmodule
